// ----- src/dual_motor_drive_watchdog_core_assert.svh -----
// Assertion macros for the dual motor drive watchdog core.
// Needs nothing else; included by files that carry concurrent assertions.
`ifndef DUAL_MOTOR_DRIVE_WATCHDOG_CORE_ASSERT_SVH
`define DUAL_MOTOR_DRIVE_WATCHDOG_CORE_ASSERT_SVH

// same-cycle implication, skipped while reset is asserted
`define DMDW_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication, skipped while reset is asserted
`define DMDW_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ----- src/dmdw_pkg.sv -----
// Shared types and constants for the dual motor drive watchdog core.
// No dependencies; used by dmdw_clamp and the top level.
`timescale 1ns / 1ps

package dmdw_pkg;

	localparam int unsigned DUTY_W = 15;
	localparam int unsigned CNT_W  = 16;
	localparam int unsigned CFG_W  = 16;

	// item kinds
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_LEFT  = 2'd1;
	localparam logic [1:0] CMD_RIGHT = 2'd2;

	// register indexes
	localparam logic [1:0] REG_PWM_LIMIT    = 2'd0;
	localparam logic [1:0] REG_CMD_TIMEOUT  = 2'd1;
	localparam logic [1:0] REG_LINK_TIMEOUT = 2'd2;

	localparam logic [DUTY_W-1:0] PWM_LIMIT_RST    = 15'd1023;
	localparam logic [CNT_W-1:0]  CMD_TIMEOUT_RST  = 16'd300;
	localparam logic [CNT_W-1:0]  LINK_TIMEOUT_RST = 16'd500;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [15:0] drive_value;
	} in_word_t;

	typedef struct packed {
		logic [DUTY_W-1:0] right_duty;
		logic              right_reverse;
		logic [DUTY_W-1:0] left_forward_duty;
		logic [DUTY_W-1:0] left_reverse_duty;
		logic              left_enable;
		logic              link_up;
	} out_word_t;

	// clamped drive as magnitude plus direction
	typedef struct packed {
		logic              reverse;
		logic [DUTY_W-1:0] mag;
	} duty_t;

endpackage

// ----- src/dual_motor_drive_watchdog_core.sv -----
// Dual motor drive with per-wheel command watchdog, top level.
// Depends on dmdw_pkg, dmdw_clamp and dual_motor_drive_watchdog_core_assert.svh.
//
//   port group   dir  handshake            word
//   in_*         in   in_valid / in_stall   dmdw_pkg::in_word_t
//   out_*        out  out_valid / out_stall dmdw_pkg::out_word_t
//   cfg_*        in   cfg_we (no wait)      cfg_index, cfg_data
//
// One word per cycle sustained while out_stall is low; each word gives one result, which passes
// through the input register, then the update of the wheel state and the result register.
// The state update is a saturating increment, compare and clamp, all combinational.
// arst_n clears counters and duties, sets link up and loads register defaults.
// out_stall holds a valid result register; the input register then fills and in_stall rises.
`timescale 1ns / 1ps
`include "dual_motor_drive_watchdog_core_assert.svh"

module dual_motor_drive_watchdog_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  dmdw_pkg::in_word_t                in_word,
	output logic                              out_valid,
	input  logic                              out_stall,
	output dmdw_pkg::out_word_t               out_word,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [dmdw_pkg::CFG_W-1:0]        cfg_data
);

	logic [dmdw_pkg::DUTY_W-1:0] pwm_limit_q;
	logic [dmdw_pkg::CNT_W-1:0]  cmd_timeout_q;
	logic [dmdw_pkg::CNT_W-1:0]  link_timeout_q;

	logic                valid_s1;
	dmdw_pkg::in_word_t  word_s1;
	logic                out_valid_q;
	dmdw_pkg::out_word_t out_word_q;

	logic [dmdw_pkg::CNT_W-1:0] left_cnt_q, right_cnt_q;
	logic [dmdw_pkg::CNT_W-1:0] left_cnt_d, right_cnt_d;
	logic [dmdw_pkg::CNT_W-1:0] left_inc, right_inc;
	dmdw_pkg::out_word_t        state_q, state_d;

	logic              advance;
	logic              fire_s1;
	logic              in_accept;
	logic signed [16:0] right_req, left_req;
	dmdw_pkg::duty_t   right_clamp, left_clamp;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_limit_q    <= dmdw_pkg::PWM_LIMIT_RST;
			cmd_timeout_q  <= dmdw_pkg::CMD_TIMEOUT_RST;
			link_timeout_q <= dmdw_pkg::LINK_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dmdw_pkg::REG_PWM_LIMIT:    pwm_limit_q    <= cfg_data[14:0];
				dmdw_pkg::REG_CMD_TIMEOUT:  cmd_timeout_q  <= cfg_data;
				dmdw_pkg::REG_LINK_TIMEOUT: link_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: the result register frees the input register
	assign advance   = !out_valid_q || !out_stall;
	assign fire_s1   = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			word_s1 <= in_word;
		end
	end

	// left wheel is driven with the negated request
	assign right_req = 17'(word_s1.drive_value);
	assign left_req  = 17'(-right_req);

	dmdw_clamp u_clamp_right (
		.value (right_req),
		.limit (pwm_limit_q),
		.duty  (right_clamp)
	);

	dmdw_clamp u_clamp_left (
		.value (left_req),
		.limit (pwm_limit_q),
		.duty  (left_clamp)
	);

	assign left_inc  = (left_cnt_q == '1) ? left_cnt_q : left_cnt_q + 1'b1;
	assign right_inc = (right_cnt_q == '1) ? right_cnt_q : right_cnt_q + 1'b1;

	always_comb begin
		state_d     = state_q;
		left_cnt_d  = left_cnt_q;
		right_cnt_d = right_cnt_q;
		unique case (word_s1.command)
			dmdw_pkg::CMD_TICK: begin
				left_cnt_d  = left_inc;
				right_cnt_d = right_inc;
				if (left_inc > cmd_timeout_q) begin
					state_d.left_forward_duty = '0;
					state_d.left_reverse_duty = '0;
				end
				if (right_inc > cmd_timeout_q) begin
					state_d.right_duty = '0;
				end
				state_d.link_up = !((left_inc > link_timeout_q) &&
					(right_inc > link_timeout_q));
			end
			dmdw_pkg::CMD_LEFT: begin
				left_cnt_d = '0;
				state_d.left_forward_duty = left_clamp.reverse ? '0 : left_clamp.mag;
				state_d.left_reverse_duty = left_clamp.reverse ? left_clamp.mag : '0;
				state_d.left_enable = 1'b1;
			end
			dmdw_pkg::CMD_RIGHT: begin
				right_cnt_d = '0;
				state_d.right_duty    = right_clamp.mag;
				state_d.right_reverse = right_clamp.reverse;
			end
			default: ; // unused code leaves state alone
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_cnt_q  <= '0;
			right_cnt_q <= '0;
			state_q     <= '{right_duty: '0, right_reverse: 1'b0, left_forward_duty: '0,
				left_reverse_duty: '0, left_enable: 1'b0, link_up: 1'b1};
		end else if (fire_s1) begin
			left_cnt_q  <= left_cnt_d;
			right_cnt_q <= right_cnt_d;
			state_q     <= state_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_word_q <= state_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	`DMDW_ASSERT_NEXT(a_right_cmd_clears_cnt, clk, arst_n, fire_s1 && (word_s1.command == dmdw_pkg::CMD_RIGHT), right_cnt_q == '0, "right command did not clear its tick count")
	`DMDW_ASSERT_IMPL(a_left_split_exclusive, clk, arst_n, 1'b1, (state_q.left_forward_duty == '0) || (state_q.left_reverse_duty == '0), "left forward and reverse duty both nonzero")
	`DMDW_ASSERT_IMPL(a_stall_only_when_full, clk, arst_n, in_stall, out_valid_q && valid_s1 && out_stall, "input stalled with a free pipeline slot")
	`DMDW_ASSERT_NEXT(a_fire_gives_result, clk, arst_n, fire_s1, out_valid_q && (out_word_q == $past(state_d)), "accepted word did not reach the result register")

endmodule

// ----- src/dmdw_clamp.sv -----
// Clamps a signed drive request to +/- limit and splits it into magnitude and direction.
// Depends on dmdw_pkg.
`timescale 1ns / 1ps

module dmdw_clamp (
	input  logic signed [16:0]               value,
	input  logic [dmdw_pkg::DUTY_W-1:0]      limit,
	output dmdw_pkg::duty_t                  duty
);

	logic [16:0] abs_val;

	assign abs_val = value[16] ? 17'(-value) : 17'(value);

	always_comb begin
		duty.mag = (abs_val > {2'b00, limit}) ? limit : abs_val[14:0];
		// a zero limit clamps a negative request to zero, which counts as forward
		duty.reverse = value[16] && (limit != '0);
	end

endmodule
